[hw/rtl/pts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task tick scheduler package
// Shared sizes, operation and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Number of task slots in the table.
  localparam int TASK_SLOTS = 8;
  // Most results that one dispatch may emit.
  localparam int RESULT_CAP = 8;

  localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RESULT_CAP + 1);
  localparam int FUNC_W = 2;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 16;
  localparam int INDEX_W = 8;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 4;
  localparam int ERR_W  = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DISP = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE  = 3'd4;

  // Sticky error codes.
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_DELETE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             do_add;
    logic             do_del;
    logic             do_tick;
    logic             do_disp;
    logic [IDX_W-1:0] idx;
    logic             last_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic disp_end;
  } sts_t;

endpackage

[hw/rtl/pts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Decodes the operation and steps the slot walk for tick and dispatch.
// ----------------------------------------------------------------------------
module pts_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pts_pkg::FUNC_W-1:0]  in_func,
  input  pts_pkg::sts_t               sts,
  output pts_pkg::cmd_t               cmd,
  output logic                        busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DEL,
    S_TICK,
    S_DISP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [pts_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                      last_step;

  assign last_step = (idx_r == pts_pkg::IDX_W'(pts_pkg::TASK_SLOTS - 1));
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = start && (state_r == S_IDLE);
    cmd.do_add    = (state_r == S_ADD);
    cmd.do_del    = (state_r == S_DEL);
    cmd.do_tick   = (state_r == S_TICK);
    cmd.do_disp   = (state_r == S_DISP);
    cmd.idx       = idx_r;
    cmd.last_step = last_step;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          unique case (in_func)
            pts_pkg::FUNC_ADD:  state_nxt = S_ADD;
            pts_pkg::FUNC_DEL:  state_nxt = S_DEL;
            pts_pkg::FUNC_TICK: state_nxt = S_TICK;
            pts_pkg::FUNC_DISP: state_nxt = S_DISP;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD, S_DEL: begin
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (last_step) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DISP: begin
        if (last_step || sts.disp_end) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[hw/rtl/pts_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Holds the slot table and the sticky error, and forms each result beat.
// ----------------------------------------------------------------------------
module pts_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pts_pkg::cmd_t                 cmd,
  output pts_pkg::sts_t                 sts,
  input  logic [pts_pkg::TAG_W-1:0]     in_task_tag,
  input  logic [pts_pkg::TIME_W-1:0]    in_start_delay,
  input  logic [pts_pkg::TIME_W-1:0]    in_run_period,
  input  logic [pts_pkg::INDEX_W-1:0]   in_slot_index,
  output logic                          out_valid,
  output logic [pts_pkg::STAT_W-1:0]    out_status,
  output logic [pts_pkg::SLOT_W-1:0]    out_slot,
  output logic [pts_pkg::TAG_W-1:0]     out_ready_tag,
  output logic                          out_last_of_run,
  output logic [pts_pkg::ERR_W-1:0]     out_sticky_error
);

  localparam int N = pts_pkg::TASK_SLOTS;

  // Slot table.
  logic [N-1:0]                valid_r, valid_nxt;
  logic [N-1:0]                ready_r, ready_nxt;
  logic [pts_pkg::TAG_W-1:0]   tag_r [N];
  logic [pts_pkg::TIME_W-1:0]  cnt_r [N];
  logic [pts_pkg::TIME_W-1:0]  per_r [N];
  logic [pts_pkg::ERR_W-1:0]   err_r, err_nxt;
  logic [pts_pkg::CNT_W-1:0]   emit_cnt_r, emit_cnt_nxt;

  // Captured operands.
  logic [pts_pkg::TAG_W-1:0]   tag_in_r;
  logic [pts_pkg::TIME_W-1:0]  delay_r;
  logic [pts_pkg::TIME_W-1:0]  period_r;
  logic [pts_pkg::INDEX_W-1:0] index_r;

  // Table write port.
  logic                        tbl_we;
  logic [pts_pkg::IDX_W-1:0]   tbl_widx;
  logic [pts_pkg::TAG_W-1:0]   tbl_tag;
  logic [pts_pkg::TIME_W-1:0]  tbl_cnt;
  logic [pts_pkg::TIME_W-1:0]  tbl_per;

  // Result beat before the output register.
  logic                        res_valid;
  logic [pts_pkg::STAT_W-1:0]  res_status;
  logic [pts_pkg::SLOT_W-1:0]  res_slot;
  logic [pts_pkg::TAG_W-1:0]   res_tag;
  logic                        res_last;

  logic                        free_found;
  logic [pts_pkg::IDX_W-1:0]   free_idx;
  logic [pts_pkg::IDX_W-1:0]   sel;
  logic [pts_pkg::IDX_W-1:0]   del_idx;
  logic                        del_in_range;
  logic [N-1:0]                above;
  logic                        hit;
  logic                        disp_last;

  assign sel          = cmd.idx;
  assign del_idx      = index_r[pts_pkg::IDX_W-1:0];
  assign del_in_range = (index_r < pts_pkg::INDEX_W'(N));

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = N - 1; j >= 0; j--) begin
      if (!valid_r[j]) begin
        free_found = 1'b1;
        free_idx   = pts_pkg::IDX_W'(j);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      above[j] = (j > int'(sel));
    end
  end

  assign hit       = valid_r[sel] && ready_r[sel];
  assign disp_last = !(|(valid_r & ready_r & above)) ||
                     (emit_cnt_r == pts_pkg::CNT_W'(pts_pkg::RESULT_CAP - 1));

  always_comb begin
    valid_nxt    = valid_r;
    ready_nxt    = ready_r;
    err_nxt      = err_r;
    emit_cnt_nxt = emit_cnt_r;
    tbl_we       = 1'b0;
    tbl_widx     = sel;
    tbl_tag      = tag_r[sel];
    tbl_cnt      = cnt_r[sel];
    tbl_per      = per_r[sel];
    res_valid    = 1'b0;
    res_status   = pts_pkg::ST_OK;
    res_slot     = '0;
    res_tag      = '0;
    res_last     = 1'b0;
    sts.disp_end = 1'b0;

    if (cmd.load) begin
      emit_cnt_nxt = '0;
    end

    if (cmd.do_add) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      if (!free_found) begin
        err_nxt    = pts_pkg::ERR_TOO_MANY;
        res_status = pts_pkg::ST_FULL;
        res_slot   = pts_pkg::SLOT_W'(N);
      end else begin
        valid_nxt[free_idx] = 1'b1;
        ready_nxt[free_idx] = 1'b0;
        tbl_we   = 1'b1;
        tbl_widx = free_idx;
        tbl_tag  = tag_in_r;
        tbl_cnt  = delay_r;
        tbl_per  = period_r;
        res_slot = pts_pkg::SLOT_W'(free_idx);
      end
    end

    if (cmd.do_del) begin
      res_valid = 1'b1;
      res_last  = 1'b1;
      if (!del_in_range) begin
        err_nxt    = pts_pkg::ERR_NO_DELETE;
        res_status = pts_pkg::ST_RANGE;
      end else begin
        if (!valid_r[del_idx]) begin
          err_nxt    = pts_pkg::ERR_NO_DELETE;
          res_status = pts_pkg::ST_EMPTY;
        end
        res_slot           = pts_pkg::SLOT_W'(index_r);
        valid_nxt[del_idx] = 1'b0;
        ready_nxt[del_idx] = 1'b0;
      end
    end

    if (cmd.do_tick) begin
      if (valid_r[sel]) begin
        tbl_we = 1'b1;
        if (cnt_r[sel] == '0) begin
          ready_nxt[sel] = 1'b1;
          tbl_cnt        = per_r[sel];
        end else begin
          tbl_cnt = cnt_r[sel] - 1'b1;
        end
      end
      if (cmd.last_step) begin
        res_valid = 1'b1;
        res_last  = 1'b1;
      end
    end

    if (cmd.do_disp) begin
      if (hit) begin
        res_valid      = 1'b1;
        res_slot       = pts_pkg::SLOT_W'(sel);
        res_tag        = tag_r[sel];
        res_last       = disp_last;
        ready_nxt[sel] = 1'b0;
        if (per_r[sel] == '0) begin
          valid_nxt[sel] = 1'b0;
        end
        emit_cnt_nxt = emit_cnt_r + 1'b1;
        sts.disp_end = disp_last;
      end else if (cmd.last_step && (emit_cnt_r == '0)) begin
        res_valid  = 1'b1;
        res_status = pts_pkg::ST_NONE;
        res_last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ready_r    <= '0;
      err_r      <= pts_pkg::ERR_NONE;
      emit_cnt_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      ready_r    <= ready_nxt;
      err_r      <= err_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      out_valid  <= res_valid;
    end
  end

  // Payload: table contents of a free slot are never observed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_in_r <= in_task_tag;
      delay_r  <= in_start_delay;
      period_r <= in_run_period;
      index_r  <= in_slot_index;
    end
    if (tbl_we) begin
      tag_r[tbl_widx] <= tbl_tag;
      cnt_r[tbl_widx] <= tbl_cnt;
      per_r[tbl_widx] <= tbl_per;
    end
    if (res_valid) begin
      out_status       <= res_status;
      out_slot         <= res_slot;
      out_ready_tag    <= res_tag;
      out_last_of_run  <= res_last;
      out_sticky_error <= err_nxt;
    end
  end

endmodule

[hw/rtl/periodic_task_tick_scheduler.sv]
`timescale 1ns / 1ps
// Add and delete: a single step in S_ADD or S_DEL; its result beat passes through the output register.
// Tick: walks every slot, one slot per cycle; one beat follows the walk.
// Dispatch: walks the slots upwards; the walk ends early after the last ready slot or the RESULT_CAP-th beat.
// Dispatch beats appear in the cycle after their slot step, through the output register.
// The receiver cannot stall: each beat is valid for exactly one cycle.
// Synchronous active-low reset empties the table and clears the sticky error.
// ----------------------------------------------------------------------------
// Periodic task tick scheduler
// A table of periodic and one-shot task slots with add, delete, tick and
// dispatch operations, built as a controller and a slot-table datapath.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel: accepted when start is high and busy is low.
  input  logic                          start,
  output logic                          busy,
  input  logic [pts_pkg::FUNC_W-1:0]    in_func,
  input  logic [pts_pkg::TAG_W-1:0]     in_task_tag,
  input  logic [pts_pkg::TIME_W-1:0]    in_start_delay,
  input  logic [pts_pkg::TIME_W-1:0]    in_run_period,
  input  logic [pts_pkg::INDEX_W-1:0]   in_slot_index,
  // Result channel: one beat per cycle in which out_valid is high.
  output logic                          out_valid,
  output logic [pts_pkg::STAT_W-1:0]    out_status,
  output logic [pts_pkg::SLOT_W-1:0]    out_slot,
  output logic [pts_pkg::TAG_W-1:0]     out_ready_tag,
  output logic                          out_last_of_run,
  output logic [pts_pkg::ERR_W-1:0]     out_sticky_error
);

  // The controller decodes the operation on acceptance and, for tick and
  // dispatch, walks the slot index from zero upwards, one slot per cycle.
  // The datapath captures the operands on acceptance, updates the addressed
  // slot on each step and writes each result beat into its output register.
  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  pts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // The sticky error seen on each beat is the value after the operation has
  // taken effect. Dispatch emits ready slots in index order and flags the
  // final beat by looking ahead at the ready bits above the current slot.
  pts_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_task_tag      (in_task_tag),
    .in_start_delay   (in_start_delay),
    .in_run_period    (in_run_period),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_ready_tag    (out_ready_tag),
    .out_last_of_run  (out_last_of_run),
    .out_sticky_error (out_sticky_error)
  );

`ifndef SYNTHESIS
  // Every beat is produced by a step that ran while the block was busy.
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // An accepted add is followed by its busy add step and then by a final beat.
  a_add_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == pts_pkg::FUNC_ADD))
      |=> busy ##1 (out_valid && out_last_of_run))
    else $error("add did not produce its single result beat");

  // A nothing-ready beat is the only beat of its dispatch and carries no tag.
  a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == pts_pkg::ST_NONE))
      |-> (out_last_of_run && (out_ready_tag == '0) && (out_slot == '0)))
    else $error("malformed nothing-ready beat");
`endif

endmodule
